[rtl/core/mep_pkg.sv]
`timescale 1ns / 1ps

package mep_pkg;

	// number formats
	localparam int FRAC_BITS  = 28;
	localparam int ITER_LIMIT = 200;
	localparam int ITER_W     = $clog2(ITER_LIMIT + 1);
	localparam int PIX_W      = 12;
	localparam int CFG_W      = 32;
	localparam int STEP_W     = 31;
	localparam int CFG_AW     = 4;
	localparam int CH_W       = 8;

	// c = origin + pixel * step
	localparam int CPROD_W = PIX_W + STEP_W;
	localparam int C_W     = ((CPROD_W + 1 > CFG_W) ? CPROD_W + 1 : CFG_W) + 1;

	// z part squares are only used while |part| <= 2.0, so magnitudes fit MAG_W
	localparam int MAG_W  = FRAC_BITS + 2;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int DIFF_W = SQ_W + 2;
	localparam int TERM_W = FRAC_BITS + 4;
	localparam int Z_W    = ((C_W > TERM_W) ? C_W : TERM_W) + 1;

	localparam logic [Z_W-1:0] Z_BOUND =
		{{(Z_W - FRAC_BITS - 2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
	localparam logic [SUM_W-1:0] SUM_FOUR = {3'b001, {(2 * FRAC_BITS + 2){1'b0}}};

	localparam logic [CH_W-1:0] RED_MUL   = CH_W'(5);
	localparam logic [CH_W-1:0] GREEN_MUL = CH_W'(10);
	localparam logic [CH_W-1:0] BLUE_MUL  = CH_W'(15);

	localparam logic [CFG_W-1:0]  ORIGIN_RE_RST  = 32'hE000_0000;
	localparam logic [CFG_W-1:0]  ORIGIN_IM_RST  = 32'hE800_0000;
	localparam logic [STEP_W-1:0] PIXEL_STEP_RST = STEP_W'(1342177);

	typedef enum logic [1:0] {
		REG_ORIGIN_RE  = 2'd0,
		REG_ORIGIN_IM  = 2'd1,
		REG_PIXEL_STEP = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  origin_re;
		logic [CFG_W-1:0]  origin_im;
		logic [STEP_W-1:0] pixel_step;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic mul;
		logic upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic esc;
		logic last;
	} stat_t;

endpackage

[rtl/core/mep_if.sv]
`timescale 1ns / 1ps

interface mep_pix_if;
	import mep_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_res_if;
	import mep_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] iterations;
	logic            in_set;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output iterations, output in_set, output red,
		output green, output blue, input ready);
	modport sink (input valid, input iterations, input in_set, input red,
		input green, input blue, output ready);
endinterface

[rtl/core/mep_cfg.sv]
`timescale 1ns / 1ps

module mep_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mep_pkg::CFG_AW-1:0] paddr,
	input  logic [mep_pkg::CFG_W-1:0]  pwdata,
	output logic [mep_pkg::CFG_W-1:0]  prdata,
	output logic                      pready,
	output mep_pkg::cfg_t             cfg
);
	import mep_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re  <= ORIGIN_RE_RST;
			cfg_q.origin_im  <= ORIGIN_IM_RST;
			cfg_q.pixel_step <= PIXEL_STEP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN_RE:  cfg_q.origin_re  <= pwdata;
				REG_ORIGIN_IM:  cfg_q.origin_im  <= pwdata;
				REG_PIXEL_STEP: cfg_q.pixel_step <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN_RE:  prdata = cfg_q.origin_re;
			REG_ORIGIN_IM:  prdata = cfg_q.origin_im;
			REG_PIXEL_STEP: prdata = CFG_W'(cfg_q.pixel_step);
			default:        prdata = '0;
		endcase
	end

endmodule

[rtl/core/mep_dp.sv]
`timescale 1ns / 1ps

module mep_dp (
	input  logic                      clk,
	input  mep_pkg::cfg_t             cfg,
	input  mep_pkg::cmd_t             cmd,
	input  logic [mep_pkg::PIX_W-1:0] pixel_x,
	input  logic [mep_pkg::PIX_W-1:0] pixel_y,
	output mep_pkg::stat_t            stat,
	output logic [mep_pkg::CH_W-1:0]  iterations,
	output logic                      in_set,
	output logic [mep_pkg::CH_W-1:0]  red,
	output logic [mep_pkg::CH_W-1:0]  green,
	output logic [mep_pkg::CH_W-1:0]  blue
);
	import mep_pkg::*;

	logic signed [CFG_W-1:0]  org_re;
	logic signed [CFG_W-1:0]  org_im;
	logic        [CPROD_W-1:0] off_re;
	logic        [CPROD_W-1:0] off_im;

	logic signed [C_W-1:0] c_re_q;
	logic signed [C_W-1:0] c_im_q;
	logic signed [Z_W-1:0] z_re_q;
	logic signed [Z_W-1:0] z_im_q;
	logic [ITER_W-1:0]     iter_q;

	logic [Z_W-1:0]   mag_re;
	logic [Z_W-1:0]   mag_im;
	logic             big;
	logic [SQ_W-1:0]  sr_q;
	logic [SQ_W-1:0]  si_q;
	logic [SQ_W-1:0]  cr_q;
	logic             neg_q;
	logic             big_q;

	logic [SUM_W-1:0]         sum;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] dbl_cr;
	logic signed [TERM_W-1:0] re_term;
	logic signed [TERM_W-1:0] im_term;
	logic signed [Z_W-1:0]    z_re_d;
	logic signed [Z_W-1:0]    z_im_d;

	logic [CH_W-1:0] it8;
	logic            at_limit;
	logic [CH_W-1:0] iterations_q;
	logic            in_set_q;
	logic [CH_W-1:0] red_q;
	logic [CH_W-1:0] green_q;
	logic [CH_W-1:0] blue_q;

	// point c
	assign org_re = cfg.origin_re;
	assign org_im = cfg.origin_im;
	assign off_re = CPROD_W'(pixel_x) * CPROD_W'(cfg.pixel_step);
	assign off_im = CPROD_W'(pixel_y) * CPROD_W'(cfg.pixel_step);

	// square phase
	assign mag_re = z_re_q[Z_W-1] ? Z_W'(-z_re_q) : Z_W'(z_re_q);
	assign mag_im = z_im_q[Z_W-1] ? Z_W'(-z_im_q) : Z_W'(z_im_q);
	assign big    = (mag_re > Z_BOUND) || (mag_im > Z_BOUND);

	// add phase: arithmetic shift gives the floor of the scaled product
	assign sum     = SUM_W'(sr_q) + SUM_W'(si_q);
	assign diff    = signed'(DIFF_W'(sr_q)) - signed'(DIFF_W'(si_q));
	assign dbl_cr  = neg_q ? -signed'(DIFF_W'({cr_q, 1'b0})) : signed'(DIFF_W'({cr_q, 1'b0}));
	assign re_term = TERM_W'(diff >>> FRAC_BITS);
	assign im_term = TERM_W'(dbl_cr >>> FRAC_BITS);
	assign z_re_d  = Z_W'(re_term) + Z_W'(c_re_q);
	assign z_im_d  = Z_W'(im_term) + Z_W'(c_im_q);

	assign stat.esc  = big_q || (sum > SUM_FOUR);
	assign stat.last = (iter_q == ITER_W'(ITER_LIMIT - 1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			c_re_q <= C_W'(org_re) + C_W'(off_re);
			c_im_q <= C_W'(org_im) + C_W'(off_im);
			z_re_q <= '0;
			z_im_q <= '0;
			iter_q <= '0;
		end
		if (cmd.mul) begin
			sr_q  <= SQ_W'(mag_re[MAG_W-1:0]) * SQ_W'(mag_re[MAG_W-1:0]);
			si_q  <= SQ_W'(mag_im[MAG_W-1:0]) * SQ_W'(mag_im[MAG_W-1:0]);
			cr_q  <= SQ_W'(mag_re[MAG_W-1:0]) * SQ_W'(mag_im[MAG_W-1:0]);
			neg_q <= z_re_q[Z_W-1] ^ z_im_q[Z_W-1];
			big_q <= big;
		end
		if (cmd.upd) begin
			z_re_q <= z_re_d;
			z_im_q <= z_im_d;
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	// result register
	assign it8      = CH_W'(iter_q);
	assign at_limit = (iter_q == ITER_W'(ITER_LIMIT));

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			iterations_q <= it8;
			in_set_q     <= at_limit;
			red_q        <= at_limit ? '0 : CH_W'(it8 * RED_MUL);
			green_q      <= at_limit ? '0 : CH_W'(it8 * GREEN_MUL);
			blue_q       <= at_limit ? '0 : CH_W'(it8 * BLUE_MUL);
		end
	end

	assign iterations = iterations_q;
	assign in_set     = in_set_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;

endmodule

[rtl/core/mep_ctrl.sv]
`timescale 1ns / 1ps

module mep_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_ready,
	output logic           res_valid,
	input  logic           res_ready,
	input  mep_pkg::stat_t stat,
	output mep_pkg::cmd_t  cmd
);
	import mep_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	assign pix_ready    = (state_q == ST_IDLE);
	assign res_valid    = res_valid_q;
	assign cmd.start    = (state_q == ST_IDLE) && pix_valid;
	assign cmd.mul      = (state_q == ST_MUL);
	assign cmd.upd      = (state_q == ST_ADD) && !stat.esc;
	// result register may be refilled in the cycle it is taken
	assign cmd.load_out = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pix_valid) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (stat.esc || stat.last) state_q <= ST_DONE;
					else state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.load_out) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/mandelbrot_escape_pixel.sv]
`timescale 1ns / 1ps

// Mandelbrot escape-time evaluator for one pixel at a time.
// pix: valid/ready stream of pixel_x, pixel_y (12 bits each). The pixel maps
// to c = origin + pixel * pixel_step (origins signed Q4.28, step unsigned Q3.28;
// APB port: origin_re at 0x0, origin_im at 0x4, pixel_step at 0x8; pready always high).
// res: valid/ready stream of iterations, in_set and the red/green/blue colour.
// An item is accepted while the block is idle. Each z = z*z + c step runs on
// the one datapath in a multiply state for the three products and an add
// state for the escape test and the new z.
// The next pixel is accepted the cycle after the result enters the output
// register, even if that result is still waiting on res.
// If the receiver stalls with a result still held, a finished pixel waits in
// the done state and pix stays not ready until the output register frees.
// Reset clears the controller and output valid and loads the default view
// (origin -2.0 - 1.5i, step 1342177).
module mandelbrot_escape_pixel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mep_pkg::CFG_AW-1:0] paddr,
	input  logic [mep_pkg::CFG_W-1:0]  pwdata,
	output logic [mep_pkg::CFG_W-1:0]  prdata,
	output logic                       pready,
	mep_pix_if.sink                    pix,
	mep_res_if.source                  res
);
	import mep_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	mep_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mep_dp u_dp (
		.clk        (clk),
		.cfg        (cfg),
		.cmd        (cmd),
		.pixel_x    (pix.pixel_x),
		.pixel_y    (pix.pixel_y),
		.stat       (stat),
		.iterations (res.iterations),
		.in_set     (res.in_set),
		.red        (res.red),
		.green      (res.green),
		.blue       (res.blue)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> !pix.ready)
		else $error("pix ready while a pixel is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && res.valid) |-> res.ready)
		else $error("result register overwritten before it was taken");

	a_in_set_black: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.in_set) |-> (res.iterations == CH_W'(ITER_LIMIT) &&
		res.red == '0 && res.green == '0 && res.blue == '0))
		else $error("in-set result with wrong count or colour");
`endif

endmodule

[bench/tb_mandelbrot_escape_pixel.sv]
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel;
	import mep_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0] iterations;
		logic            in_set;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_colour_t;

	localparam logic signed [127:0] ESCAPE_R2 = 128'sd1 <<< (2 * FRAC_BITS + 2);
	localparam logic [CFG_AW-1:0]   UNUSED_ADDR = 4'hC;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	mep_pix_if pix_ch();
	mep_res_if res_ch();

	mandelbrot_escape_pixel i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_ch),
		.res     (res_ch)
	);

	// local copy of the view registers
	logic signed [CFG_W-1:0] view_re;
	logic signed [CFG_W-1:0] view_im;
	logic [STEP_W-1:0]       view_step;

	pixel_colour_t colours_due[$];
	int          mismatches = 0;
	int          results_seen = 0;
	bit          gaps_on = 1'b1;
	int unsigned res_hold = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 8)
			return 0;
		if (r < 15)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [CFG_AW-1:0] cfg_addr(input reg_idx_t r);
		return {r, 2'b00};
	endfunction

	function automatic void view_apply(input logic [CFG_AW-1:0] addr,
		input logic [CFG_W-1:0] data);
		if (addr == cfg_addr(REG_ORIGIN_RE))
			view_re = data;
		else if (addr == cfg_addr(REG_ORIGIN_IM))
			view_im = data;
		else if (addr == cfg_addr(REG_PIXEL_STEP))
			view_step = data[STEP_W-1:0];
	endfunction

	// escape-time count and colour for one pixel under the current view
	function automatic pixel_colour_t escape_time(input logic [PIX_W-1:0] px,
		input logic [PIX_W-1:0] py);
		longint             c_re, c_im, z_re, z_im;
		logic signed [127:0] zr, zi, sq_re, sq_im, t;
		int unsigned        steps;
		pixel_colour_t      r;
		c_re = longint'(view_re) + longint'(px) * longint'(view_step);
		c_im = longint'(view_im) + longint'(py) * longint'(view_step);
		z_re = 0;
		z_im = 0;
		steps = 0;
		while (steps < ITER_LIMIT) begin
			zr = z_re;
			zi = z_im;
			sq_re = zr * zr;
			sq_im = zi * zi;
			if (sq_re + sq_im > ESCAPE_R2)
				break;
			// arithmetic shift gives the floor of the scaled product
			t = (sq_re - sq_im) >>> FRAC_BITS;
			z_re = longint'(t[63:0]) + c_re;
			t = ((zr * zi) <<< 1) >>> FRAC_BITS;
			z_im = longint'(t[63:0]) + c_im;
			steps++;
		end
		r.iterations = steps[CH_W-1:0];
		r.in_set = (steps == ITER_LIMIT);
		if (r.in_set) begin
			r.red = '0;
			r.green = '0;
			r.blue = '0;
		end else begin
			r.red = steps[CH_W-1:0] * RED_MUL;
			r.green = steps[CH_W-1:0] * GREEN_MUL;
			r.blue = steps[CH_W-1:0] * BLUE_MUL;
		end
		return r;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// result checker
	always @(posedge clk) begin
		pixel_colour_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.iterations, res_ch.in_set, res_ch.red, res_ch.green,
				res_ch.blue};
			results_seen++;
			if (colours_due.size() == 0) begin
				log_mismatch($sformatf("result %0d arrived with none pending: iter=%0d",
					results_seen, got.iterations));
			end else begin
				want = colours_due.pop_front();
				if (got.iterations != want.iterations || got.in_set != want.in_set ||
					got.red != want.red || got.green != want.green ||
					got.blue != want.blue) begin
					log_mismatch($sformatf(
						"result %0d: expected iter=%0d in_set=%0b rgb=%0d/%0d/%0d, got iter=%0d in_set=%0b rgb=%0d/%0d/%0d",
						results_seen, want.iterations, want.in_set, want.red,
						want.green, want.blue, got.iterations, got.in_set, got.red,
						got.green, got.blue));
				end
			end
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (res_hold != 0)
			res_hold <= res_hold - 1;
	end

	initial begin
		int ready_gap;
		ready_gap = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (res_hold != 0) begin
				res_ch.ready <= 1'b0;
			end else if (ready_gap != 0) begin
				res_ch.ready <= 1'b0;
				ready_gap--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					ready_gap = pick_gap();
			end
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
		int gap;
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_x <= px;
		pix_ch.pixel_y <= py;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		colours_due.push_back(escape_time(px, py));
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			pix_ch.valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (colours_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		view_apply(addr, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_read(input logic [CFG_AW-1:0] addr, output logic [CFG_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_view_regs();
		logic [CFG_W-1:0] rd;
		reg_read(cfg_addr(REG_ORIGIN_RE), rd);
		if (rd != view_re)
			log_mismatch($sformatf("origin_re read: expected %h, got %h", view_re, rd));
		reg_read(cfg_addr(REG_ORIGIN_IM), rd);
		if (rd != view_im)
			log_mismatch($sformatf("origin_im read: expected %h, got %h", view_im, rd));
		reg_read(cfg_addr(REG_PIXEL_STEP), rd);
		if (rd[STEP_W-1:0] != view_step)
			log_mismatch($sformatf("pixel_step read: expected %h, got %h", view_step,
				rd[STEP_W-1:0]));
	endtask

	// registers change only once every pending result is back
	task automatic set_view(input logic [CFG_W-1:0] re, input logic [CFG_W-1:0] im,
		input logic [CFG_W-1:0] step);
		drain_results();
		reg_write(cfg_addr(REG_ORIGIN_RE), re);
		reg_write(cfg_addr(REG_ORIGIN_IM), im);
		reg_write(cfg_addr(REG_PIXEL_STEP), step);
	endtask

	// mostly pixels inside the window, some anywhere in the pixel range
	task automatic run_window(input int n_items, input logic [CFG_W-1:0] re,
		input logic [CFG_W-1:0] im, input logic [CFG_W-1:0] step, input int span);
		set_view(re, im, step);
		repeat (n_items) begin
			if ($urandom_range(0, 9) == 0)
				send_pixel(PIX_W'($urandom_range(0, 4095)),
					PIX_W'($urandom_range(0, 4095)));
			else
				send_pixel(PIX_W'($urandom_range(0, span)),
					PIX_W'($urandom_range(0, span)));
		end
	endtask

	task automatic test_reset_view();
		check_view_regs();
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(400, 280);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		send_pixel(300, 300);
		send_pixel(150, 300);
		// cusp at c = 0.25
		send_pixel(450, 300);
	endtask

	task automatic test_edge_views();
		set_view(32'd0, 32'd0, 32'd0);
		send_pixel(4095, 4095);
		// c = -2 exactly: |z|^2 sits on 4 forever
		set_view(32'hE000_0000, 32'd0, 32'd0);
		send_pixel(0, 0);
		// just right of the cusp, long escapes so the colours wrap
		set_view(32'd69793219, 32'd0, 32'd0);
		send_pixel(0, 0);
		set_view(32'd67377300, 32'd0, 32'd0);
		send_pixel(0, 0);
		// top bit of pixel_step is dropped
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		reg_write(cfg_addr(REG_PIXEL_STEP), 32'hFFFF_FFFF);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(4095, 0);
		set_view(32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
		send_pixel(1, 0);
		send_pixel(0, 4095);
		drain_results();
		reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
		check_view_regs();
		send_pixel(1, 0);
	endtask

	task automatic test_result_stall();
		set_view(32'hE000_0000, 32'hE800_0000, 32'd1342177);
		@(negedge clk);
		res_hold = 1500;
		repeat (8)
			send_pixel(PIX_W'($urandom_range(0, 640)), PIX_W'($urandom_range(0, 600)));
	endtask

	task automatic test_sender_pause();
		repeat (10)
			send_pixel(PIX_W'($urandom_range(0, 640)), PIX_W'($urandom_range(0, 600)));
		drain_results();
		repeat (10)
			send_pixel(PIX_W'($urandom_range(0, 640)), PIX_W'($urandom_range(0, 600)));
	endtask

	task automatic test_random_views();
		longint     zoom_re[4] = '{-200064945, 76504105, -335544320, -42949673};
		longint     zoom_im[4] = '{30252676, 2684355, 0, 279172874};
		logic [30:0] step;
		longint     re0, im0;
		int         span;
		// whole set in view; the middle pass runs with no idling
		for (int k = 0; k < 3; k++) begin
			gaps_on = (k != 1);
			step = STEP_W'($urandom_range(1_000_000, 3_000_000));
			span = 858993459 / step;
			re0 = -590558003 + longint'($urandom_range(0, 20_000_000)) - 10_000_000;
			im0 = -429496730 + longint'($urandom_range(0, 20_000_000)) - 10_000_000;
			run_window(210, 32'(re0), 32'(im0), CFG_W'(step), span);
		end
		gaps_on = 1'b1;
		step = STEP_W'($urandom_range(220_000, 400_000));
		span = 858993459 / step;
		if (span > 4095)
			span = 4095;
		run_window(200, 32'hDCCC_CCCD, 32'hE666_6666, CFG_W'(step), span);
		// close views around points on the boundary
		for (int k = 0; k < 4; k++) begin
			step = STEP_W'($urandom_range(2000, 40000));
			re0 = zoom_re[k] - 255 * longint'(step);
			im0 = zoom_im[k] - 255 * longint'(step);
			run_window(120, 32'(re0), 32'(im0), CFG_W'(step), 511);
		end
		run_window(100, $urandom, $urandom, $urandom, 4095);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		view_re = ORIGIN_RE_RST;
		view_im = ORIGIN_IM_RST;
		view_step = PIXEL_STEP_RST;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_view();
		test_edge_views();
		test_result_stall();
		test_sender_pause();
		test_random_views();

		drain_results();
		repeat (450)
			@(posedge clk);
		if (mismatches == 0 && colours_due.size() == 0)
			$display("** mandelbrot_escape_pixel: PASSED **");
		else
			$display("** mandelbrot_escape_pixel: FAILED **");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("** mandelbrot_escape_pixel: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/core/mep_pkg.sv
rtl/core/mep_if.sv
rtl/core/mep_cfg.sv
rtl/core/mep_dp.sv
rtl/core/mep_ctrl.sv
rtl/core/mandelbrot_escape_pixel.sv
bench/tb_mandelbrot_escape_pixel.sv
